/* rtl/lacp_pkg.sv */
// Shared types, character codes and lookup functions for the LED and
// accessory command parser. No dependencies.
`default_nettype none

package lacp_pkg;

    // Input transaction: one character or an end-of-line marker.
    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } in_item_t;

    // Output transaction: one status result per line.
    typedef struct packed {
        logic       status;
        logic [7:0] red_duty;
        logic [7:0] green_duty;
        logic [7:0] blue_duty;
        logic       extractor_on;
        logic       laser_on;
    } out_item_t;

    // Per-line capture seen by the command decoder.
    typedef struct packed {
        logic [3:0] char_position;
        logic [7:0] first_char;
        logic [7:0] second_char;
        logic [7:0] third_char;
        logic [7:0] fourth_char;
        logic [7:0] hex_byte0;
        logic [7:0] hex_byte1;
        logic [7:0] hex_byte2;
    } line_t;

    // Persistent outputs kept across lines.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       extractor;
        logic       laser;
    } acc_state_t;

    localparam logic STATUS_ACCEPTED = 1'b0;
    localparam logic STATUS_INVALID  = 1'b1;

    localparam logic [2:0] ADDR_LASER_CTRL = 3'd0;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_B  = 8'h42;
    localparam logic [7:0] CHAR_UP_E  = 8'h45;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_UP_G  = 8'h47;
    localparam logic [7:0] CHAR_UP_L  = 8'h4C;
    localparam logic [7:0] CHAR_UP_R  = 8'h52;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;

    localparam logic [3:0] POS_MAX = 4'd15;

    // Hex digit value; anything that is not a hex digit counts as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = c[3:0];
        end else if ((c >= CHAR_UP_A && c <= CHAR_UP_F) ||
                     (c >= CHAR_LO_A && c <= CHAR_LO_F)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    // Ten-step brightness table indexed by a decimal digit.
    function automatic logic [7:0] level_of(input logic [3:0] d);
        logic [7:0] v;
        unique case (d)
            4'd0:    v = 8'h00;
            4'd1:    v = 8'h0F;
            4'd2:    v = 8'h1F;
            4'd3:    v = 8'h2F;
            4'd4:    v = 8'h3F;
            4'd5:    v = 8'h4F;
            4'd6:    v = 8'h5F;
            4'd7:    v = 8'h6F;
            4'd8:    v = 8'h7F;
            4'd9:    v = 8'hFF;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/lacp_line_state.sv */
// Per-line character capture: first four characters and the hex pairs.
// Depends on lacp_pkg.
`default_nettype none

module lacp_line_state
    import lacp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic       clear,
    input  wire logic [7:0] char_code,
    output line_t           line
);

    logic [3:0] pos_reg;
    logic [7:0] c0_reg, c1_reg, c2_reg, c3_reg;
    logic [3:0] high_reg;
    logic [7:0] hb0_reg, hb1_reg, hb2_reg;
    logic       ended_reg;

    logic       in_hex;
    logic [7:0] pair;

    assign in_hex = (pos_reg >= 4'd2) && (pos_reg <= 4'd7) && !ended_reg;
    assign pair   = {high_reg, hex_value(char_code)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            c0_reg    <= '0;
            c1_reg    <= '0;
            c2_reg    <= '0;
            c3_reg    <= '0;
            high_reg  <= '0;
            hb0_reg   <= '0;
            hb1_reg   <= '0;
            hb2_reg   <= '0;
            ended_reg <= 1'b0;
        end
        else if (clear)
        begin
            pos_reg   <= '0;
            c0_reg    <= '0;
            c1_reg    <= '0;
            c2_reg    <= '0;
            c3_reg    <= '0;
            high_reg  <= '0;
            hb0_reg   <= '0;
            hb1_reg   <= '0;
            hb2_reg   <= '0;
            ended_reg <= 1'b0;
        end
        else if (take)
        begin
            if (pos_reg == 4'd0) c0_reg <= char_code;
            if (pos_reg == 4'd1) c1_reg <= char_code;
            if (pos_reg == 4'd2) c2_reg <= char_code;
            if (pos_reg == 4'd3) c3_reg <= char_code;

            if (in_hex)
            begin
                // A zero byte ends the string: freeze the hex run.
                if (char_code == CHAR_NUL)
                begin
                    ended_reg <= 1'b1;
                end
                else if (!pos_reg[0])
                begin
                    high_reg <= hex_value(char_code);
                end
                else
                begin
                    if (pos_reg[2:1] == 2'd1) hb0_reg <= pair;
                    if (pos_reg[2:1] == 2'd2) hb1_reg <= pair;
                    if (pos_reg[2:1] == 2'd3) hb2_reg <= pair;
                end
            end

            if (pos_reg != POS_MAX) pos_reg <= pos_reg + 4'd1;
        end
    end

    assign line.char_position = pos_reg;
    assign line.first_char    = c0_reg;
    assign line.second_char   = c1_reg;
    assign line.third_char    = c2_reg;
    assign line.fourth_char   = c3_reg;
    assign line.hex_byte0     = hb0_reg;
    assign line.hex_byte1     = hb1_reg;
    assign line.hex_byte2     = hb2_reg;

endmodule

`default_nettype wire

/* rtl/lacp_exec.sv */
// Command decoder: turns a captured line into new LED/accessory state
// and a status bit. Purely combinational. Depends on lacp_pkg.
`default_nettype none

module lacp_exec
    import lacp_pkg::*;
(
    input  wire line_t      line,
    input  wire acc_state_t cur,
    input  wire logic       laser_en,
    output acc_state_t      nxt,
    output logic            status
);

    logic       color_ok;
    logic       digit_ok;
    logic [7:0] level;

    assign color_ok = (line.third_char == CHAR_UP_R) || (line.third_char == CHAR_UP_G) ||
                      (line.third_char == CHAR_UP_B);
    assign digit_ok = (line.fourth_char >= CHAR_ZERO) && (line.fourth_char <= CHAR_NINE);
    assign level    = level_of(line.fourth_char[3:0]);

    always_comb
    begin
        nxt    = cur;
        status = STATUS_INVALID;
        priority if (line.first_char == CHAR_STAR)
        begin
            if (line.second_char == CHAR_UP_L)
            begin
                nxt.red   = line.hex_byte0;
                nxt.green = line.hex_byte1;
                nxt.blue  = line.hex_byte2;
                status    = STATUS_ACCEPTED;
            end
        end
        else if (line.first_char == CHAR_UP_A)
        begin
            unique case (line.second_char)
                CHAR_UP_L:
                begin
                    if (line.third_char == CHAR_ZERO)
                    begin
                        nxt.red   = '0;
                        nxt.green = '0;
                        nxt.blue  = '0;
                        status    = STATUS_ACCEPTED;
                    end
                    else if (color_ok && digit_ok)
                    begin
                        if (line.third_char == CHAR_UP_R) nxt.red = level;
                        if (line.third_char == CHAR_UP_G) nxt.green = level;
                        if (line.third_char == CHAR_UP_B) nxt.blue = level;
                        status = STATUS_ACCEPTED;
                    end
                end
                CHAR_UP_E:
                begin
                    nxt.extractor = 1'b1;
                    status        = STATUS_ACCEPTED;
                end
                CHAR_UP_F:
                begin
                    nxt.extractor = 1'b0;
                    status        = STATUS_ACCEPTED;
                end
                CHAR_UP_Z:
                begin
                    if (laser_en)
                    begin
                        nxt.laser = 1'b1;
                        status    = STATUS_ACCEPTED;
                    end
                end
                CHAR_UP_X:
                begin
                    if (laser_en)
                    begin
                        nxt.laser = 1'b0;
                        status    = STATUS_ACCEPTED;
                    end
                end
                default:
                begin
                    status = STATUS_INVALID;
                end
            endcase
        end
        else
        begin
            status = STATUS_INVALID;
        end
    end

endmodule

`default_nettype wire

/* rtl/lacp_out_queue.sv */
// Two-entry result queue: output register plus skid register.
// Depends on lacp_pkg.
`default_nettype none

module lacp_out_queue
    import lacp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire out_item_t  push_data,
    output logic            full,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_data
);

    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      skid_valid_reg;
    out_item_t skid_data_reg;
    logic      pop;

    assign pop = out_valid_reg && !out_stall;

    // Push never arrives while the skid entry is occupied (full stalls it).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop || !out_valid_reg)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/led_accessory_command_parser_unit.sv */
// Top level of the LED and accessory command parser: input register,
// line capture, decoder, persistent state and result queue. Depends on lacp_pkg.
`default_nettype none

// Takes one character transaction per clock while in_stall is low and returns
// one status transaction for each end-of-line transaction, carrying the LED
// duties and accessory levels after that line. Every transaction first lands
// in an input register; in the next cycle a character updates the line
// capture, while an end-of-line, once the result queue has room, is decoded
// against the capture in one short combinational pass and written to the
// result queue, from which the result is presented. Throughput is one
// transaction per cycle while the input does not stall. The output register
// and a skid register hold up to two results; the input side stalls only
// when both are full and the input register holds another end-of-line.
// Laser on/off commands are honored only while the laser control register
// (byte address 0, bit 0) is set; write it while the block is idle.
module led_accessory_command_parser_unit
    import lacp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic       s1_valid_reg;
    in_item_t   s1_data_reg;
    logic       laser_en_reg;
    acc_state_t acc_reg;
    acc_state_t acc_next;

    line_t      line;
    logic       status;
    logic       q_full;
    logic       advance;
    logic       take_char;
    logic       end_line;
    out_item_t  result;

    // Configuration port: zero-wait writes, register 0 only.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LASER_CTRL) ? {31'd0, laser_en_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            laser_en_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_LASER_CTRL)
        begin
            laser_en_reg <= pwdata[0];
        end
    end

    // Hold the input register only when an end-of-line has nowhere to go.
    assign in_stall  = s1_valid_reg && s1_data_reg.line_end && q_full;
    assign advance   = s1_valid_reg && !in_stall;
    assign take_char = advance && !s1_data_reg.line_end;
    assign end_line  = advance && s1_data_reg.line_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            s1_data_reg <= in_data;
        end
    end

    lacp_line_state u_line
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take_char),
        .clear     (end_line),
        .char_code (s1_data_reg.char_code),
        .line      (line)
    );

    lacp_exec u_exec
    (
        .line     (line),
        .cur      (acc_reg),
        .laser_en (laser_en_reg),
        .nxt      (acc_next),
        .status   (status)
    );

    // Advance the persistent duties and flags only when a line executes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (end_line)
        begin
            acc_reg <= acc_next;
        end
    end

    assign result.status       = status;
    assign result.red_duty     = acc_next.red;
    assign result.green_duty   = acc_next.green;
    assign result.blue_duty    = acc_next.blue;
    assign result.extractor_on = acc_next.extractor;
    assign result.laser_on     = acc_next.laser;

    lacp_out_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (end_line),
        .push_data (result),
        .full      (q_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // The skid entry is only ever filled behind an occupied output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> out_valid)
        else $error("result skid entry valid with empty output register");

    // An executed line always leaves a result waiting.
    a_line_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        end_line |=> out_valid)
        else $error("executed line produced no result");

    // The line capture starts over after every line end.
    a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        end_line |=> (line.char_position == 4'd0 && line.first_char == CHAR_NUL))
        else $error("line capture not cleared after line end");

    // Persistent state changes only when a line executes.
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !end_line |=> $stable(acc_reg))
        else $error("LED/accessory state changed without a line end");

endmodule

`default_nettype wire

/* tb/tb_led_accessory_command_parser_unit.sv */
// Self-checking testbench for the LED and accessory command parser: directed
// and random command lines, random idling on both sides, laser control toggled.
// Depends on lacp_pkg and led_accessory_command_parser_unit.
`default_nettype none

module tb_led_accessory_command_parser_unit;
    import lacp_pkg::*;

    // Random part: total input transactions, split evenly over the phases.
    localparam int unsigned RANDOM_ITEMS   = 1700;
    localparam int unsigned NUM_PHASES     = 6;
    // Laser control setting per phase, bit n for phase n.
    localparam bit [NUM_PHASES-1:0] LASER_PLAN = 6'b011010;
    // Cycles without any transaction or register access before giving up.
    localparam int unsigned WATCHDOG_LIMIT = 400;
    // Cycles to let the pipeline settle after the last expected status.
    localparam int unsigned SETTLE_CYCLES  = 4;

    typedef enum int {
        LK_HEX,
        LK_ALL_OFF,
        LK_LEVEL,
        LK_FAN_ON,
        LK_FAN_OFF,
        LK_BEAM_ON,
        LK_BEAM_OFF,
        LK_NOISE
    } line_kind_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    led_accessory_command_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Transactions waiting for the driver, and status transactions that the
    // parser owes us, oldest first.
    in_item_t    pending_xacts[$];
    out_item_t   expected_status[$];
    logic [7:0]  line_buf[$];
    int unsigned items_made = 0;
    int unsigned errors = 0;

    // Handshake results of the last rising edge, seen by the falling-edge drivers.
    logic        in_acc = 1'b0;
    logic        out_acc = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit          in_calm = 1'b0;
    int unsigned quiet_cycles = 0;

    // Predicted parser state: the line being collected...
    logic [3:0]  ln_count;
    logic [7:0]  ln_chr [0:3];
    logic [3:0]  hi_nib;
    logic [7:0]  pairs [0:2];
    logic        hex_stop;
    // ...and what persists across lines.
    logic [7:0]  led_r = 8'h00;
    logic [7:0]  led_g = 8'h00;
    logic [7:0]  led_b = 8'h00;
    logic        fan_on = 1'b0;
    logic        beam_on = 1'b0;
    logic        laser_allowed = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Value of a hex digit; anything else counts as zero.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            v = c - CHAR_ZERO;
        else if (c >= CHAR_UP_A && c <= CHAR_UP_F)
            v = c - CHAR_UP_A + 8'd10;
        else if (c >= CHAR_LO_A && c <= CHAR_LO_F)
            v = c - CHAR_LO_A + 8'd10;
        return v[3:0];
    endfunction

    // Ten-step brightness ladder for the single-colour command.
    function automatic logic [7:0] duty_step(input logic [3:0] d);
        if (d == 4'd0)
            return 8'h00;
        if (d == 4'd9)
            return 8'hFF;
        return {d - 4'd1, 4'hF};
    endfunction

    task automatic clear_line_state();
        ln_count = 4'd0;
        for (int i = 0; i < 4; i++)
            ln_chr[i] = CHAR_NUL;
        hi_nib = 4'd0;
        for (int i = 0; i < 3; i++)
            pairs[i] = 8'h00;
        hex_stop = 1'b0;
    endtask

    // Advance the predicted state by one accepted input transaction; a line
    // end decodes the collected line and queues the status it must produce.
    task automatic parse_transaction(input in_item_t it);
        out_item_t  res;
        logic       status;
        logic [7:0] lvl;
        logic [7:0] digit;
        logic [3:0] pair_pos;
        if (!it.line_end)
        begin
            if (ln_count < 4'd4)
                ln_chr[ln_count[1:0]] = it.char_code;
            // Hex pairs live in positions 2..7; a NUL ends the run for good.
            if (ln_count >= 4'd2 && ln_count <= 4'd7 && !hex_stop)
            begin
                pair_pos = ln_count - 4'd2;
                if (it.char_code == CHAR_NUL)
                    hex_stop = 1'b1;
                else if (!ln_count[0])
                    hi_nib = nibble_of(it.char_code);
                else
                    pairs[pair_pos[2:1]] = {hi_nib, nibble_of(it.char_code)};
            end
            if (ln_count != POS_MAX)
                ln_count = ln_count + 4'd1;
        end
        else
        begin
            status = STATUS_INVALID;
            if (ln_chr[0] == CHAR_STAR)
            begin
                if (ln_chr[1] == CHAR_UP_L)
                begin
                    led_r = pairs[0];
                    led_g = pairs[1];
                    led_b = pairs[2];
                    status = STATUS_ACCEPTED;
                end
            end
            else if (ln_chr[0] == CHAR_UP_A)
            begin
                case (ln_chr[1])
                    CHAR_UP_L:
                    begin
                        if (ln_chr[2] == CHAR_ZERO)
                        begin
                            led_r = 8'h00;
                            led_g = 8'h00;
                            led_b = 8'h00;
                            status = STATUS_ACCEPTED;
                        end
                        else if ((ln_chr[2] == CHAR_UP_R || ln_chr[2] == CHAR_UP_G ||
                                  ln_chr[2] == CHAR_UP_B) &&
                                 ln_chr[3] >= CHAR_ZERO && ln_chr[3] <= CHAR_NINE)
                        begin
                            digit = ln_chr[3] - CHAR_ZERO;
                            lvl = duty_step(digit[3:0]);
                            if (ln_chr[2] == CHAR_UP_R)
                                led_r = lvl;
                            else if (ln_chr[2] == CHAR_UP_G)
                                led_g = lvl;
                            else
                                led_b = lvl;
                            status = STATUS_ACCEPTED;
                        end
                    end
                    CHAR_UP_E:
                    begin
                        fan_on = 1'b1;
                        status = STATUS_ACCEPTED;
                    end
                    CHAR_UP_F:
                    begin
                        fan_on = 1'b0;
                        status = STATUS_ACCEPTED;
                    end
                    CHAR_UP_Z:
                    begin
                        if (laser_allowed)
                        begin
                            beam_on = 1'b1;
                            status = STATUS_ACCEPTED;
                        end
                    end
                    CHAR_UP_X:
                    begin
                        if (laser_allowed)
                        begin
                            beam_on = 1'b0;
                            status = STATUS_ACCEPTED;
                        end
                    end
                    default:
                        status = STATUS_INVALID;
                endcase
            end
            res.status       = status;
            res.red_duty     = led_r;
            res.green_duty   = led_g;
            res.blue_duty    = led_b;
            res.extractor_on = fan_on;
            res.laser_on     = beam_on;
            expected_status.push_back(res);
            clear_line_state();
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    // Compare one accepted status transaction with the oldest prediction.
    task automatic check_status(input out_item_t got);
        out_item_t want;
        if (expected_status.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected status transaction, expected none, actual %h",
                     $time, got);
        end
        else
        begin
            want = expected_status.pop_front();
            if (got.status !== want.status)
                note_mismatch("status", want.status, got.status);
            if (got.red_duty !== want.red_duty)
                note_mismatch("red_duty", want.red_duty, got.red_duty);
            if (got.green_duty !== want.green_duty)
                note_mismatch("green_duty", want.green_duty, got.green_duty);
            if (got.blue_duty !== want.blue_duty)
                note_mismatch("blue_duty", want.blue_duty, got.blue_duty);
            if (got.extractor_on !== want.extractor_on)
                note_mismatch("extractor_on", want.extractor_on, got.extractor_on);
            if (got.laser_on !== want.laser_on)
                note_mismatch("laser_on", want.laser_on, got.laser_on);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge, check outputs
    // before feeding the predictor, and run the watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        logic took_in;
        logic took_out;
        took_in  = rst_n && in_valid && !in_stall;
        took_out = rst_n && out_valid && !out_stall;
        if (took_out)
            check_status(out_data);
        if (took_in)
            parse_transaction(in_data);
        in_acc  <= took_in;
        out_acc <= took_out;
        // Any handshake or register access counts as progress.
        if (took_in || took_out || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb_led_accessory_command_parser_unit: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input driver: hold a stalled transaction, otherwise wait out the drawn
    // gap, then present the next pending transaction. Switch now and then
    // into a calm stretch with no gaps at all.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_acc)
        begin
            // hold payload and valid until the parser takes it
        end
        else if (gap_left != 0)
        begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_xacts.size() != 0)
        begin
            if ($urandom_range(0, 29) == 0)
                in_calm = !in_calm;
            in_data  <= pending_xacts.pop_front();
            in_valid <= 1'b1;
            gap_left <= in_calm ? 0 : $urandom_range(0, 13);
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output stall: draw a fresh stall length after every accepted status and
    // burn it down only while a status is shown, so the stall hits results.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : stall_gen
        int unsigned n;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            n = out_acc ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13))
                        : stall_left;
            out_stall  <= (n != 0);
            stall_left <= (n != 0 && out_valid) ? n - 1 : n;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic put(input logic [7:0] c);
        line_buf.push_back(c);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // Turn the collected characters into transactions and close the line; the
    // character byte of the line-end transaction is random since it is ignored.
    task automatic send_line();
        in_item_t it;
        foreach (line_buf[i])
        begin
            it.char_code = line_buf[i];
            it.line_end  = 1'b0;
            pending_xacts.push_back(it);
        end
        it.char_code = $urandom_range(0, 255);
        it.line_end  = 1'b1;
        pending_xacts.push_back(it);
        items_made += line_buf.size() + 1;
        line_buf.delete();
    endtask

    task automatic send_text(input string s);
        add_text(s);
        send_line();
    endtask

    function automatic logic [7:0] any_hex_char();
        logic [7:0] c;
        case ($urandom_range(0, 2))
            0:       c = CHAR_ZERO + $urandom_range(0, 9);
            1:       c = CHAR_UP_A + $urandom_range(0, 5);
            default: c = CHAR_LO_A + $urandom_range(0, 5);
        endcase
        return c;
    endfunction

    // Mostly characters that steer the decoder, plus arbitrary bytes and NUL.
    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0:       c = CHAR_STAR;
            1:       c = CHAR_UP_A;
            2:       c = CHAR_UP_L;
            3:       c = CHAR_UP_E;
            4:       c = CHAR_UP_Z;
            5:       c = CHAR_NUL;
            6:       c = CHAR_ZERO;
            default: c = $urandom_range(0, 255);
        endcase
        return c;
    endfunction

    // One random command line: mostly well-formed commands with random content,
    // the rest noise, with a trailing tail now and then (sometimes past the
    // position limit).
    task automatic random_line();
        line_kind_t  kind;
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (r < 25)
            kind = LK_HEX;
        else if (r < 32)
            kind = LK_ALL_OFF;
        else if (r < 52)
            kind = LK_LEVEL;
        else if (r < 59)
            kind = LK_FAN_ON;
        else if (r < 66)
            kind = LK_FAN_OFF;
        else if (r < 74)
            kind = LK_BEAM_ON;
        else if (r < 82)
            kind = LK_BEAM_OFF;
        else
            kind = LK_NOISE;

        case (kind)
            LK_HEX:
            begin
                put(CHAR_STAR);
                put(CHAR_UP_L);
                n = ($urandom_range(0, 2) != 0) ? 6 : $urandom_range(0, 6);
                repeat (n)
                begin
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        put(CHAR_NUL);
                    else if (r < 3)
                        put($urandom_range(0, 255));
                    else
                        put(any_hex_char());
                end
            end
            LK_ALL_OFF:
            begin
                put(CHAR_UP_A);
                put(CHAR_UP_L);
                put(CHAR_ZERO);
            end
            LK_LEVEL:
            begin
                put(CHAR_UP_A);
                put(CHAR_UP_L);
                case ($urandom_range(0, 2))
                    0:       put(CHAR_UP_R);
                    1:       put(CHAR_UP_G);
                    default: put(CHAR_UP_B);
                endcase
                if ($urandom_range(0, 9) == 0)
                    put($urandom_range(0, 255));
                else
                    put(CHAR_ZERO + $urandom_range(0, 9));
            end
            LK_FAN_ON:
            begin
                put(CHAR_UP_A);
                put(CHAR_UP_E);
            end
            LK_FAN_OFF:
            begin
                put(CHAR_UP_A);
                put(CHAR_UP_F);
            end
            LK_BEAM_ON:
            begin
                put(CHAR_UP_A);
                put(CHAR_UP_Z);
            end
            LK_BEAM_OFF:
            begin
                put(CHAR_UP_A);
                put(CHAR_UP_X);
            end
            default:
            begin
                repeat ($urandom_range(0, 5))
                    put(noise_char());
            end
        endcase

        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 20))
                put($urandom_range(0, 255));
        send_line();
    endtask

    // Register write: setup cycle, then access cycle; the register takes the
    // value at the rising edge of the access cycle. Upper data bits are random
    // and must not matter.
    task automatic cfg_write(input logic [2:0] addr, input logic setting);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = {31'($urandom_range(0, 32'h7FFF_FFFF)), setting};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        laser_allowed = setting;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        @(posedge clk);
        #1;
    endtask

    // Wait until every transaction is sent and every status has come back,
    // then let the pipeline settle so trailing characters are absorbed too.
    task automatic drain();
        while (pending_xacts.size() != 0 || in_valid || expected_status.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        #1;
    endtask

    // Directed lines with laser control off: every command, colour extremes,
    // partial and non-hex colour strings, NUL handling, short and long lines.
    task automatic directed_laser_off();
        send_text("*LFFFFFF");
        send_text("*L000000");
        send_text("*Lfa9B0c");
        send_text("*L12345");
        send_text("*L1");
        send_text("*LG7zz9!");
        // NUL inside the colour string stops the hex run
        put(CHAR_STAR);
        add_text("L12");
        put(CHAR_NUL);
        add_text("34");
        send_line();
        send_text("ALR9");
        send_text("ALG1");
        send_text("ALB5");
        send_text("ALRx");
        send_text("ALQ3");
        send_text("AL0");
        send_text("AEtrailing-characters-past-limit");
        send_text("AF");
        // laser commands are refused while laser control is off
        send_text("AZ");
        send_text("AX");
        send_text("*X");
        send_text("");
        send_text("A");
        send_text("AL");
        // NUL in a command position matches nothing
        put(CHAR_UP_A);
        put(CHAR_NUL);
        add_text("E");
        send_line();
    endtask

    // ------------------------------------------------------------------
    // Sequencer: reset once, then run the phases, each with its own laser
    // control setting written while the parser is idle.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned phase_end;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = ADDR_LASER_CTRL;
        pwdata    = 32'd0;
        clear_line_state();
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            cfg_write(ADDR_LASER_CTRL, LASER_PLAN[ph]);
            if (ph == 0)
                directed_laser_off();
            if (ph == 1)
            begin
                send_text("AZ");
                send_text("AX");
                send_text("AZjunk");
            end
            phase_end = items_made + RANDOM_ITEMS / NUM_PHASES;
            while (items_made < phase_end)
                random_line();
            drain();
        end

        if (errors == 0)
            $display("tb_led_accessory_command_parser_unit: done, clean");
        else
            $display("tb_led_accessory_command_parser_unit: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
